// ----- rtl/phh_pkg.sv -----
// Package for the sampling profiler histogram: item codes, queue and result types.
// No dependencies; imported by the core, front end, back end and test.
package phh_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic CFG_DIVIDER  = 1'b0;
    localparam logic CFG_DURATION = 1'b1;

    localparam logic [31:0] HASH_MULT    = 32'd31;
    localparam logic [31:0] CNT_MAX      = 32'hFFFF_FFFF;
    localparam logic [10:0] USED_OUT_MAX = 11'd2047;

    // Item as it sits in the queue, with the hash key already formed.
    typedef struct packed {
        op_t         op;
        logic [15:0] thread_id;
        logic        thread_valid;
        logic [31:0] sample_pc;
        logic [9:0]  read_index;
        logic [31:0] key;
    } qitem_t;

    typedef struct packed {
        logic [15:0] thread;
        logic [31:0] pc;
        logic [31:0] hits;
    } slot_t;

    typedef struct packed {
        logic        running;
        logic [31:0] total_samples;
        logic [31:0] missed_samples;
        logic [10:0] entries_used;
        logic        entry_valid;
        logic [15:0] entry_thread;
        logic [31:0] entry_pc;
        logic [31:0] entry_count;
    } result_t;

endpackage

// ----- rtl/phh_if.sv -----
// Channel interfaces of the profiler: input items and result items.
// Depends on nothing.
interface phh_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] thread_id;
    logic        thread_valid;
    logic [31:0] sample_pc;
    logic [9:0]  read_index;

    modport source (output valid, op, thread_id, thread_valid, sample_pc, read_index,
                    input ready);
    modport sink (input valid, op, thread_id, thread_valid, sample_pc, read_index,
                  output ready);
endinterface

interface phh_result_if;
    logic        valid;
    logic        ready;
    logic        running;
    logic [31:0] total_samples;
    logic [31:0] missed_samples;
    logic [10:0] entries_used;
    logic        entry_valid;
    logic [15:0] entry_thread;
    logic [31:0] entry_pc;
    logic [31:0] entry_count;

    modport source (output valid, running, total_samples, missed_samples, entries_used,
                    entry_valid, entry_thread, entry_pc, entry_count, input ready);
    modport sink (input valid, running, total_samples, missed_samples, entries_used,
                  entry_valid, entry_thread, entry_pc, entry_count, output ready);
endinterface

// ----- rtl/pc_sample_hash_histogram_core.sv -----
// Sampling profiler with a linear-probing (thread, pc) histogram table.
// A tick, stop or out-of-range read goes straight to the result; an in-range read
// reads its slot first; a recorded sample is hashed, then probes slot by slot.
// One item at a time in the back end. Start clears the table at one slot per cycle.
// Reset: async active low; clears control state, then sweeps the table clear.
module pc_sample_hash_histogram_core
    import phh_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    phh_item_if.sink      items,
    phh_result_if.source  results,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data
);

    logic [15:0] divider_reg;
    logic [31:0] duration_reg;
    logic        q_valid;
    qitem_t      q_item;
    logic        q_pop;
    logic        res_valid;
    result_t     res_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg  <= 16'd1;
            duration_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DIVIDER)
            begin
                divider_reg <= cfg_data[15:0];
            end
            if (cfg_index == CFG_DURATION)
            begin
                duration_reg <= cfg_data;
            end
        end
    end

    phh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (items.valid),
        .in_ready     (items.ready),
        .op           (items.op),
        .thread_id    (items.thread_id),
        .thread_valid (items.thread_valid),
        .sample_pc    (items.sample_pc),
        .read_index   (items.read_index),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    phh_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_divider (divider_reg),
        .run_limit      (duration_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .res_valid      (res_valid),
        .res_data       (res_data),
        .res_ready      (results.ready)
    );

    assign results.valid          = res_valid;
    assign results.running        = res_data.running;
    assign results.total_samples  = res_data.total_samples;
    assign results.missed_samples = res_data.missed_samples;
    assign results.entries_used   = res_data.entries_used;
    assign results.entry_valid    = res_data.entry_valid;
    assign results.entry_thread   = res_data.entry_thread;
    assign results.entry_pc       = res_data.entry_pc;
    assign results.entry_count    = res_data.entry_count;

endmodule

// ----- rtl/phh_front.sv -----
// Front end: accepts items, forms the hash key and queues them (two entries).
// Depends on phh_pkg.
module phh_front
    import phh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] thread_id,
    input  logic        thread_valid,
    input  logic [31:0] sample_pc,
    input  logic [9:0]  read_index,
    output logic        q_valid,
    output qitem_t      q_item,
    input  logic        q_pop
);

    qitem_t     slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    qitem_t     new_item;
    logic       push;

    always_comb
    begin
        new_item.op           = op_t'(op);
        new_item.thread_id    = thread_id;
        new_item.thread_valid = thread_valid;
        new_item.sample_pc    = sample_pc;
        new_item.read_index   = read_index;
        new_item.key          = 32'(thread_id) * HASH_MULT + {2'b00, sample_pc[31:2]};
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ----- rtl/phh_back.sv -----
// Back end: runs ticks, hashes, probes the slot table, serves reads, holds the result.
// Depends on phh_pkg.
module phh_back
    import phh_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] sample_divider,
    input  logic [31:0] run_limit,
    input  logic        q_valid,
    input  qitem_t      q_item,
    output logic        q_pop,
    output logic        res_valid,
    output result_t     res_data,
    input  logic        res_ready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST    = AW'(TABLE_DEPTH - 1);
    // Keys stay below 2^31; this reciprocal gives the exact quotient for all of them.
    localparam int            HASH_SHIFT = 31 + AW;
    localparam logic [32:0]   HASH_RECIP = 33'(((longint'(1) << HASH_SHIFT)
                                                + longint'(TABLE_DEPTH) - 64'sd1)
                                               / longint'(TABLE_DEPTH));

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_HASH  = 7'b0000100,
        ST_PROBE = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    slot_t mem [TABLE_DEPTH];
    slot_t rd_data;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    slot_t         wr_data;

    state_t        state_reg, state_next;
    qitem_t        cur_reg, cur_next;
    logic          active_reg, active_next;
    logic [31:0]   total_reg, total_next;
    logic [31:0]   missed_reg, missed_next;
    logic [AW:0]   used_reg, used_next;
    logic [15:0]   phase_reg, phase_next;
    logic [31:0]   ticks_reg, ticks_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   quot_reg, quot_next;
    logic          step_reg, step_next;
    logic          start_pend_reg, start_pend_next;
    slot_t         entry_reg, entry_next;
    logic          ev_reg, ev_next;
    logic          res_valid_reg, res_valid_next;
    result_t       res_reg, res_next;

    logic [63:0]   hash_prod;
    logic [31:0]   hash_quot;
    logic [31:0]   hash_rem_w;
    logic [AW-1:0] hash_rem;
    logic [15:0]   div;
    logic [15:0]   phase_inc;
    logic [31:0]   ridx_w;

    // Key mod depth in two steps: reciprocal multiply for the quotient, then subtract.
    assign hash_prod  = 64'(key_reg[30:0]) * 64'(HASH_RECIP);
    assign hash_quot  = 32'(hash_prod >> HASH_SHIFT);
    assign hash_rem_w = key_reg - quot_reg * 32'(TABLE_DEPTH);
    assign hash_rem   = hash_rem_w[AW-1:0];

    assign div       = (sample_divider == 16'd0) ? 16'd1 : sample_divider;
    assign phase_inc = phase_reg + 16'd1;
    assign ridx_w    = 32'(q_item.read_index);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        active_next     = active_reg;
        total_next      = total_reg;
        missed_next     = missed_reg;
        used_next       = used_reg;
        phase_next      = phase_reg;
        ticks_next      = ticks_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        clr_next        = clr_reg;
        key_next        = key_reg;
        quot_next       = quot_reg;
        step_next       = step_reg;
        start_pend_next = start_pend_reg;
        entry_next      = entry_reg;
        ev_next         = ev_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        q_pop           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST)
                begin
                    state_next      = start_pend_reg ? ST_DONE : ST_IDLE;
                    start_pend_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    entry_next = '0;
                    ev_next    = 1'b0;
                    state_next = ST_DONE;
                    case (q_item.op)
                        OP_TICK:
                        begin
                            if (active_reg)
                            begin
                                if (run_limit != 32'd0 && ticks_reg >= run_limit)
                                begin
                                    active_next = 1'b0;
                                end
                                else
                                begin
                                    ticks_next = (ticks_reg == CNT_MAX) ? ticks_reg
                                                                        : ticks_reg + 32'd1;
                                    if (phase_inc >= div)
                                    begin
                                        phase_next = 16'd0;
                                        if (q_item.thread_valid)
                                        begin
                                            total_next = (total_reg == CNT_MAX) ? total_reg
                                                                                : total_reg + 32'd1;
                                            key_next   = q_item.key;
                                            step_next  = 1'b0;
                                            state_next = ST_HASH;
                                        end
                                    end
                                    else
                                    begin
                                        phase_next = phase_inc;
                                    end
                                end
                            end
                        end
                        OP_START:
                        begin
                            active_next     = 1'b1;
                            total_next      = '0;
                            missed_next     = '0;
                            used_next       = '0;
                            phase_next      = '0;
                            ticks_next      = '0;
                            clr_next        = '0;
                            start_pend_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        OP_STOP:
                        begin
                            active_next = 1'b0;
                        end
                        default:
                        begin
                            if (ridx_w < 32'(TABLE_DEPTH))
                            begin
                                rd_addr    = ridx_w[AW-1:0];
                                state_next = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_HASH:
            begin
                if (!step_reg)
                begin
                    quot_next = hash_quot;
                    step_next = 1'b1;
                end
                else
                begin
                    idx_next   = hash_rem;
                    cnt_next   = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                wr_addr = idx_reg;
                if (rd_data.hits == 32'd0)
                begin
                    wr_en        = 1'b1;
                    wr_data.thread = cur_reg.thread_id;
                    wr_data.pc     = cur_reg.sample_pc;
                    wr_data.hits   = 32'd1;
                    used_next    = used_reg + (AW+1)'(1);
                    state_next   = ST_DONE;
                end
                else if (rd_data.thread == cur_reg.thread_id && rd_data.pc == cur_reg.sample_pc)
                begin
                    wr_en        = 1'b1;
                    wr_data      = rd_data;
                    wr_data.hits = (rd_data.hits == CNT_MAX) ? rd_data.hits
                                                             : rd_data.hits + 32'd1;
                    state_next   = ST_DONE;
                end
                else if (cnt_reg == LAST)
                begin
                    missed_next = (missed_reg == CNT_MAX) ? missed_reg : missed_reg + 32'd1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    idx_next   = (idx_reg == LAST) ? '0 : idx_reg + AW'(1);
                    cnt_next   = cnt_reg + AW'(1);
                    state_next = ST_PROBE;
                end
            end
            ST_READ:
            begin
                if (rd_data.hits != 32'd0)
                begin
                    entry_next = rd_data;
                    ev_next    = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.running        = active_reg;
                    res_next.total_samples  = total_reg;
                    res_next.missed_samples = missed_reg;
                    res_next.entries_used   = (32'(used_reg) > 32'(USED_OUT_MAX))
                                              ? USED_OUT_MAX : 11'(used_reg);
                    res_next.entry_valid    = ev_reg;
                    res_next.entry_thread   = entry_reg.thread;
                    res_next.entry_pc       = entry_reg.pc;
                    res_next.entry_count    = entry_reg.hits;
                    res_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            active_reg     <= 1'b0;
            total_reg      <= '0;
            missed_reg     <= '0;
            used_reg       <= '0;
            phase_reg      <= '0;
            ticks_reg      <= '0;
            clr_reg        <= '0;
            start_pend_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            total_reg      <= total_next;
            missed_reg     <= missed_next;
            used_reg       <= used_next;
            phase_reg      <= phase_next;
            ticks_reg      <= ticks_next;
            clr_reg        <= clr_next;
            start_pend_reg <= start_pend_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        key_reg   <= key_next;
        quot_reg  <= quot_next;
        step_reg  <= step_next;
        entry_reg <= entry_next;
        ev_reg    <= ev_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// ----- rtl/phh_checker.sv -----
// Port-level checks for the profiler core, attached by bind.
// Depends on the ports of pc_sample_hash_histogram_core.
module phh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        running,
    input logic [31:0] total_samples,
    input logic [31:0] missed_samples,
    input logic        entry_valid,
    input logic [15:0] entry_thread,
    input logic [31:0] entry_pc,
    input logic [31:0] entry_count
);

    // Hold a stalled result.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total_samples)
            && $stable(entry_count) && $stable(running))
        else $error("result changed while stalled");

    // An occupied slot has at least one hit.
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_valid |-> entry_count != 32'd0)
        else $error("valid entry with zero count");

    // Fields of an empty or non-read result are zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_valid |-> entry_thread == 16'd0 && entry_pc == 32'd0
            && entry_count == 32'd0)
        else $error("entry fields set without entry_valid");

    // Every missed sample also counts as taken.
    a_missed_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> missed_samples <= total_samples)
        else $error("missed samples exceed total");

endmodule

bind pc_sample_hash_histogram_core phh_checker u_phh_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .running        (results.running),
    .total_samples  (results.total_samples),
    .missed_samples (results.missed_samples),
    .entry_valid    (results.entry_valid),
    .entry_thread   (results.entry_thread),
    .entry_pc       (results.entry_pc),
    .entry_count    (results.entry_count)
);

// ----- dv/pc_sample_hash_histogram_core_test.sv -----
// Self-checking test of pc_sample_hash_histogram_core: a clocked driver, a clocked monitor
// and a behavioral profiler/histogram predictor compare every result item field by field.
// Depends on rtl/phh_pkg.sv, rtl/phh_if.sv and rtl/pc_sample_hash_histogram_core.sv.
`timescale 1ns / 1ps

module pc_sample_hash_histogram_core_test;
    import phh_pkg::*;

    localparam int DEPTH = 1024;

    typedef struct {
        op_t         op;
        logic [15:0] tid;
        logic        tvalid;
        logic [31:0] pc;
        logic [9:0]  ridx;
    } prof_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    phh_item_if   items ();
    phh_result_if results ();

    pc_sample_hash_histogram_core #(.TABLE_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Predictor state
    logic [15:0] hist_thread [DEPTH];
    logic [31:0] hist_pc [DEPTH];
    logic [31:0] hist_hits [DEPTH];
    bit          prof_running;
    logic [31:0] sample_count;
    logic [31:0] miss_count;
    int          used_count;
    logic [15:0] div_phase;
    logic [31:0] tick_count;
    logic [15:0] divider_reg;
    logic [31:0] duration_reg;

    prof_item_t  pending_items [$];
    result_t     expected_results [$];
    int          error_count;
    int          sent_count;
    bit          item_taken;
    int          send_idle_pct;
    int          recv_stall_pct;

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    function automatic void clear_profile();
        for (int i = 0; i < DEPTH; i++)
        begin
            hist_thread[i] = '0;
            hist_pc[i]     = '0;
            hist_hits[i]   = '0;
        end
        sample_count = '0;
        miss_count   = '0;
        used_count   = 0;
        div_phase    = '0;
        tick_count   = '0;
    endfunction

    function automatic void record_sample(logic [15:0] tid, logic [31:0] pc);
        logic [63:0] h;
        int          idx;
        h   = {48'd0, tid} * 64'd31 + {32'd0, pc >> 2};
        idx = int'(h % DEPTH);
        sample_count = sat_inc(sample_count);
        for (int n = 0; n < DEPTH; n++)
        begin
            if (hist_hits[idx] == 0)
            begin
                hist_thread[idx] = tid;
                hist_pc[idx]     = pc;
                hist_hits[idx]   = 32'd1;
                used_count++;
                return;
            end
            if (hist_thread[idx] == tid && hist_pc[idx] == pc)
            begin
                hist_hits[idx] = sat_inc(hist_hits[idx]);
                return;
            end
            idx = (idx + 1) % DEPTH;
        end
        miss_count = sat_inc(miss_count);
    endfunction

    function automatic void predict_item(prof_item_t s);
        result_t     r;
        logic [15:0] div;
        r = '0;
        case (s.op)
            OP_TICK:
            begin
                if (prof_running)
                begin
                    if (duration_reg != 0 && tick_count >= duration_reg)
                        prof_running = 1'b0;
                    else
                    begin
                        tick_count = sat_inc(tick_count);
                        div        = (divider_reg == 0) ? 16'd1 : divider_reg;
                        div_phase  = div_phase + 16'd1;
                        if (div_phase >= div)
                        begin
                            div_phase = '0;
                            if (s.tvalid)
                                record_sample(s.tid, s.pc);
                        end
                    end
                end
            end
            OP_START:
            begin
                clear_profile();
                prof_running = 1'b1;
            end
            OP_STOP:
                prof_running = 1'b0;
            default:
            begin
                if (hist_hits[s.ridx] != 0)
                begin
                    r.entry_valid  = 1'b1;
                    r.entry_thread = hist_thread[s.ridx];
                    r.entry_pc     = hist_pc[s.ridx];
                    r.entry_count  = hist_hits[s.ridx];
                end
            end
        endcase
        r.running        = prof_running;
        r.total_samples  = sample_count;
        r.missed_samples = miss_count;
        r.entries_used   = (used_count > 2047) ? USED_OUT_MAX : 11'(used_count);
        expected_results.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Driver: predict on acceptance, present the next item at the falling edge
    always @(posedge clk)
    begin
        if (rst_n && items.valid && items.ready)
        begin
            predict_item('{op_t'(items.op), items.thread_id, items.thread_valid,
                           items.sample_pc, items.read_index});
            item_taken <= 1'b1;
        end
        else
            item_taken <= 1'b0;
    end

    always @(negedge clk)
    begin
        prof_item_t s;
        if (rst_n && (!items.valid || item_taken))
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s = pending_items.pop_front();
                items.op           <= s.op;
                items.thread_id    <= s.tid;
                items.thread_valid <= s.tvalid;
                items.sample_pc    <= s.pc;
                items.read_index   <= s.ridx;
                items.valid        <= 1'b1;
                sent_count++;
                send_idle_pct  <= (sent_count < 433) ? 9 : (sent_count < 866) ? 52 : 0;
                recv_stall_pct <= (sent_count < 433) ? 52 : (sent_count < 866) ? 9 : 0;
            end
            else
                items.valid <= 1'b0;
        end
        results.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none, actual running=%b total=%h",
                         $time, results.running, results.total_samples);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("running", 32'(want.running), 32'(results.running));
                check_field("total_samples", want.total_samples, results.total_samples);
                check_field("missed_samples", want.missed_samples, results.missed_samples);
                check_field("entries_used", 32'(want.entries_used), 32'(results.entries_used));
                check_field("entry_valid", 32'(want.entry_valid), 32'(results.entry_valid));
                check_field("entry_thread", 32'(want.entry_thread), 32'(results.entry_thread));
                check_field("entry_pc", want.entry_pc, results.entry_pc);
                check_field("entry_count", want.entry_count, results.entry_count);
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        if (idx == CFG_DIVIDER)
            divider_reg = value[15:0];
        else
            duration_reg = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending_items.size() == 0 && !items.valid && expected_results.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic add_item(op_t op, logic [15:0] tid, logic tv, logic [31:0] pc,
                            logic [9:0] ridx);
        pending_items.push_back('{op, tid, tv, pc, ridx});
    endtask

    // Random run with a small pool of hot pairs so the histogram gets repeat hits
    task automatic random_run(int count);
        logic [15:0] pool_tid [4];
        logic [31:0] pool_pc [4];
        int          pick;
        for (int i = 0; i < 4; i++)
        begin
            pool_tid[i] = 16'($urandom);
            pool_pc[i]  = $urandom;
        end
        add_item(OP_START, '0, 1'b0, '0, '0);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if ($urandom_range(99) < 80)
                begin
                    pick = $urandom_range(3);
                    add_item(OP_TICK, pool_tid[pick], $urandom_range(99) < 85,
                             pool_pc[pick], 10'($urandom));
                end
                else
                    add_item(OP_TICK, 16'($urandom), 1'($urandom), $urandom, 10'($urandom));
            end
            else if (pick < 85)
                add_item(OP_READ, 16'($urandom), 1'($urandom), $urandom, 10'($urandom));
            else if (pick < 92)
                add_item(OP_STOP, 16'($urandom), 1'($urandom), $urandom, 10'($urandom));
            else
                add_item(OP_START, 16'($urandom), 1'($urandom), $urandom, 10'($urandom));
        end
        wait_drained();
    endtask

    initial
    begin
        items.valid        = 1'b0;
        items.op           = OP_TICK;
        items.thread_id    = '0;
        items.thread_valid = 1'b0;
        items.sample_pc    = '0;
        items.read_index   = '0;
        results.ready      = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_DIVIDER;
        cfg_data           = '0;
        error_count        = 0;
        sent_count         = 0;
        item_taken         = 1'b0;
        send_idle_pct      = 9;
        recv_stall_pct     = 52;
        prof_running       = 1'b0;
        divider_reg        = 16'd1;
        duration_reg       = '0;
        clear_profile();
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: stopped ops, extremes, collision, invalid thread, restart
        add_item(OP_TICK, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, '0);
        add_item(OP_STOP, '0, 1'b0, '0, '0);
        add_item(OP_READ, '0, 1'b0, '0, 10'd0);
        add_item(OP_START, '0, 1'b0, '0, '0);
        add_item(OP_TICK, 16'd0, 1'b1, 32'd0, '0);
        add_item(OP_TICK, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, '0);
        add_item(OP_TICK, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, '0);
        add_item(OP_TICK, 16'd1, 1'b1, 32'd0, '0);
        add_item(OP_TICK, 16'd0, 1'b1, 32'd124, '0);   // same start slot as (1, 0)
        add_item(OP_TICK, 16'd0, 1'b1, 32'd127, '0);   // slot 31, differs only in low pc bits
        add_item(OP_TICK, 16'd5, 1'b0, 32'h1234_5678, '0);
        add_item(OP_READ, '0, 1'b0, '0, 10'd0);
        add_item(OP_READ, '0, 1'b0, '0, 10'd31);
        add_item(OP_READ, '0, 1'b0, '0, 10'd32);
        add_item(OP_READ, '0, 1'b0, '0, 10'd33);
        add_item(OP_READ, '0, 1'b0, '0, 10'h3FF);
        add_item(OP_START, '0, 1'b0, '0, '0);
        add_item(OP_READ, '0, 1'b0, '0, 10'd0);
        add_item(OP_TICK, 16'd7, 1'b1, 32'h8000_0000, '0);
        add_item(OP_STOP, '0, 1'b0, '0, '0);
        add_item(OP_TICK, 16'd7, 1'b1, 32'h8000_0000, '0);
        add_item(OP_STOP, '0, 1'b0, '0, '0);
        wait_drained();

        // Run limit of three ticks with divider at zero
        write_reg(CFG_DIVIDER, 32'd0);
        write_reg(CFG_DURATION, 32'd3);
        add_item(OP_START, '0, 1'b0, '0, '0);
        repeat (5) add_item(OP_TICK, 16'd9, 1'b1, 32'h40, '0);
        wait_drained();

        // Fill the table until it overflows
        write_reg(CFG_DIVIDER, 32'd1);
        write_reg(CFG_DURATION, 32'd0);
        add_item(OP_START, '0, 1'b0, '0, '0);
        for (int i = 0; i < DEPTH + 12; i++)
            add_item(OP_TICK, 16'($urandom), 1'b1, $urandom, '0);
        for (int i = 0; i < 30; i++)
            add_item(OP_READ, '0, 1'b0, '0, 10'($urandom));
        add_item(OP_TICK, hist_thread[0], 1'b1, hist_pc[0], '0);
        wait_drained();

        // Random runs over several settings
        write_reg(CFG_DIVIDER, 32'd3);
        write_reg(CFG_DURATION, 32'hFFFF_FFFF);
        random_run(40);
        write_reg(CFG_DIVIDER, 32'd65535);
        write_reg(CFG_DURATION, 32'd20);
        random_run(30);
        write_reg(CFG_DIVIDER, 32'd6);
        write_reg(CFG_DURATION, 32'd0);
        random_run(40);
        // lower the divider while the run is active
        add_item(OP_START, '0, 1'b0, '0, '0);
        repeat (4) add_item(OP_TICK, 16'd3, 1'b1, 32'h100, '0);
        wait_drained();
        write_reg(CFG_DIVIDER, 32'd2);
        repeat (6) add_item(OP_TICK, 16'd3, 1'b1, 32'h100, '0);
        add_item(OP_READ, '0, 1'b0, '0, 10'd0);
        wait_drained();
        write_reg(CFG_DIVIDER, 32'd1);
        write_reg(CFG_DURATION, 32'd50);
        random_run(60);
        write_reg(CFG_DURATION, 32'd0);
        random_run(60);

        repeat (50) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
